// File: rtl/nic_pkg.sv
// Shared types and constants for the nibble-coded processor step block.
// Holds the request/response word layouts, opcodes, command and status codes.
// No dependencies; imported by nibble_isa_cpu_step.
`default_nettype none

package nic_pkg;

   localparam int unsigned PROG_WORDS = 64;
   localparam int unsigned PS_AW      = $clog2(PROG_WORDS);
   localparam int unsigned PC_W       = 16;
   localparam int unsigned DATA_W     = 16;
   localparam int unsigned WORD_W     = 20;
   localparam int unsigned REG_N      = 16;
   localparam int unsigned REG_AW     = 4;
   localparam int unsigned PADDR_W    = 6;
   // PC-sized compare width that can also hold PROG_WORDS itself
   localparam int unsigned CMP_W      = PC_W + 1;
   // byte data store split into an even and an odd bank of halfword rows
   localparam int unsigned BANK_AW    = 15;
   localparam int unsigned BANK_ROWS  = 1 << BANK_AW;
   localparam int unsigned FQ_DEPTH   = 8;
   localparam int unsigned FQ_AW      = $clog2(FQ_DEPTH);

   localparam logic [3:0] OPC_ADD = 4'h0;
   localparam logic [3:0] OPC_LW  = 4'h2;
   localparam logic [3:0] OPC_SW  = 4'h3;
   localparam logic [3:0] OPC_BEQ = 4'h4;
   localparam logic [3:0] OPC_J   = 4'hE;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_PRESET = 2'd1,
      CMD_EXEC   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_HALT  = 2'd1,
      ST_UNSUP = 2'd2
   } status_type;

   typedef enum logic {
      MODE_CLEAR = 1'b0,
      MODE_RUN   = 1'b1
   } mode_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [PADDR_W-1:0]   prog_addr;
      logic [WORD_W-1:0]    prog_word;
      logic [REG_AW-1:0]    preset_index;
      logic [DATA_W-1:0]    preset_value;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [PC_W-1:0]      pc_after;
      logic [3:0]           executed_opcode;
      logic                 reg_write_valid;
      logic [REG_AW-1:0]    reg_write_index;
      logic [DATA_W-1:0]    reg_write_value;
      logic                 mem_write_valid;
      logic [DATA_W-1:0]    mem_write_addr;
      logic [DATA_W-1:0]    mem_write_value;
   } rsp_type;

   // per-item control carried down the pipeline
   typedef struct packed {
      cmd_type              cmd;
      logic                 halt;
      logic [REG_AW-1:0]    idx;
      logic [DATA_W-1:0]    val;
   } stg_type;

endpackage

`default_nettype wire

// File: rtl/nibble_isa_cpu_step.sv
// Top level of the nibble-coded processor step block.
// Program store, register file, two-bank data store, pipeline and response queue.
// Depends on nic_pkg.
`default_nettype none

// Each request word loads a program slot, presets a register or executes one
// instruction; each gives exactly one response word, in order. Requests run
// through three stages: fetch (program store read), register read (two-port
// register file memory, write-first bypass from the write-back stage) and
// execute/memory (ALU, branch, data store access), with write-back and the
// response pushed in the cycle after. Load and preset words are taken every
// cycle. An execute word is taken only when the fetch stage is empty, because
// its PC and register operands are resolved by the item ahead of it, so a new
// instruction is not taken while the one before it is still in fetch.
// Responses wait in an 8-deep queue; new words are taken only while the queue
// has room for all words in flight, so rsp_ready backpressure never stalls the
// pipeline. After reset the 64 KiB data store is zeroed one halfword row per
// cycle: req_ready stays low until every row has been cleared.
module nibble_isa_cpu_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire nic_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output nic_pkg::rsp_type      rsp_data
);
   import nic_pkg::*;

   // ---------------- control: reset clearing pass ----------------
   mode_type                mode_ff, mode_in;
   logic [BANK_AW-1:0]      clr_ff, clr_in;
   logic                    clearing;

   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_CLEAR: begin
            if (clr_ff == BANK_AW'(BANK_ROWS - 1)) mode_in = MODE_RUN;
         end
         MODE_RUN: begin
            mode_in = MODE_RUN;
         end
         default: begin
            mode_in = MODE_CLEAR;
         end
      endcase
   end

   always_comb begin
      clearing = (mode_ff == MODE_CLEAR);
      clr_in   = clearing ? clr_ff + BANK_AW'(1) : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CLEAR;
         clr_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         clr_ff  <= clr_in;
      end
   end

   // ---------------- pipeline declarations ----------------
   logic                    f_vld_ff, f_vld_in, r_vld_ff, r_vld_in, m_vld_ff, m_vld_in;
   stg_type                 f_ff, f_in, r_ff, r_in;
   logic [WORD_W-1:0]       r_word_ff, r_word_in;
   logic [PC_W-1:0]         pc_ff, pc_in, pc_next, pc_cur;
   rsp_type                 m_rsp_ff, m_rsp_in, m_rsp;
   logic                    m_lw_ff, m_lw_in, m_a0_ff, m_a0_in;

   logic [FQ_AW:0]          fq_cnt_ff, fq_cnt_in;
   logic [FQ_AW-1:0]        fq_wp_ff, fq_wp_in, fq_rp_ff, fq_rp_in;
   logic [FQ_AW+1:0]        occ;
   logic                    fq_push, fq_pop;

   logic                    accept, is_exec_req, halt_now, r_exec_ok;

   // ---------------- acceptance ----------------
   always_comb begin
      occ = (FQ_AW+2)'(fq_cnt_ff) + (FQ_AW+2)'(f_vld_ff) + (FQ_AW+2)'(r_vld_ff)
          + (FQ_AW+2)'(m_vld_ff);
      is_exec_req = (req_data.cmd == CMD_EXEC);
      // hold an execute word while the fetch stage is busy
      req_ready = !clearing && (occ < (FQ_AW+2)'(FQ_DEPTH)) && !(is_exec_req && f_vld_ff);
      accept    = req_valid && req_ready;
   end

   // ---------------- program store ----------------
   logic [WORD_W-1:0]       ps_mem [PROG_WORDS];
   logic [PROG_WORDS-1:0]   ps_vld_ff;
   logic [WORD_W-1:0]       ps_rd_ff;
   logic                    ps_ok_ff;
   logic [CMP_W-1:0]        pa_ext;
   logic                    ps_we;
   logic [PS_AW-1:0]        ps_waddr, ps_raddr;

   always_comb begin
      // forward the PC of an execute still in the execute stage
      pc_cur   = r_exec_ok ? pc_next : pc_ff;
      halt_now = {1'b0, pc_cur} >= CMP_W'(PROG_WORDS);
      ps_raddr = pc_cur[PS_AW-1:0];
      pa_ext   = CMP_W'(req_data.prog_addr);
      ps_waddr = pa_ext[PS_AW-1:0];
      ps_we    = accept && (req_data.cmd == CMD_LOAD) && (pa_ext < CMP_W'(PROG_WORDS));
   end

   always_ff @(posedge clock) begin
      if (ps_we) ps_mem[ps_waddr] <= req_data.prog_word;
      ps_rd_ff <= ps_mem[ps_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_vld_ff <= '0;
         ps_ok_ff  <= 1'b0;
      end else begin
         if (ps_we) ps_vld_ff[ps_waddr] <= 1'b1;
         ps_ok_ff <= ps_vld_ff[ps_raddr];
      end
   end

   // ---------------- fetch stage: decode, register read ----------------
   logic [WORD_W-1:0]       f_word;
   logic [REG_AW-1:0]       rf_ra, rf_rb, rf_wi;
   logic [DATA_W-1:0]       rf_mem [REG_N];
   logic [REG_N-1:0]        rf_vld_ff;
   logic [DATA_W-1:0]       rda_ff, rdb_ff, rda_in, rdb_in, rf_wd;
   logic                    rf_we;

   always_comb begin
      f_in.cmd  = req_data.cmd;
      f_in.halt = halt_now;
      f_in.idx  = req_data.preset_index;
      f_in.val  = req_data.preset_value;
      f_vld_in  = accept;

      f_word = ps_ok_ff ? ps_rd_ff : '0;
      rf_ra  = f_word[11:8];
      rf_rb  = (f_word[19:16] == OPC_ADD) ? f_word[7:4] : f_word[15:12];

      // write-first bypass from write-back
      if (rf_we && (rf_wi == rf_ra)) rda_in = rf_wd;
      else rda_in = rf_vld_ff[rf_ra] ? rf_mem[rf_ra] : '0;
      if (rf_we && (rf_wi == rf_rb)) rdb_in = rf_wd;
      else rdb_in = rf_vld_ff[rf_rb] ? rf_mem[rf_rb] : '0;

      r_vld_in  = f_vld_ff;
      r_in      = f_ff;
      r_word_in = f_word;
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_wi] <= rf_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_wi] <= 1'b1;
      end
   end

   // ---------------- execute stage ----------------
   logic [3:0]              r_opc;
   logic [DATA_W:0]         sum_w;
   logic [PC_W:0]           pc_inc_w;
   logic                    r_lw, r_sw;
   logic [BANK_AW-1:0]      even_idx, odd_idx, even_wa, odd_wa;
   logic [7:0]              even_wd, odd_wd, even_q_ff, odd_q_ff;
   logic                    bank_we;
   logic [7:0]              ds_even [BANK_ROWS];
   logic [7:0]              ds_odd  [BANK_ROWS];

   always_comb begin
      r_opc     = r_word_ff[19:16];
      r_exec_ok = r_vld_ff && (r_ff.cmd == CMD_EXEC) && !r_ff.halt;
      pc_inc_w  = {1'b0, pc_ff} + (PC_W+1)'(1);
      sum_w     = {1'b0, rda_ff} + {1'b0, rdb_ff};

      case (r_opc)
         OPC_BEQ: pc_next = (rda_ff == rdb_ff) ? PC_W'(r_word_ff[3:0]) : pc_inc_w[PC_W-1:0];
         OPC_J:   pc_next = r_word_ff[PC_W-1:0];
         default: pc_next = pc_inc_w[PC_W-1:0];
      endcase

      pc_in = r_exec_ok ? pc_next : pc_ff;

      m_rsp_in          = '0;
      m_rsp_in.status   = ST_OK;
      m_rsp_in.pc_after = pc_ff;
      case (r_ff.cmd)
         CMD_PRESET: begin
            m_rsp_in.reg_write_valid = 1'b1;
            m_rsp_in.reg_write_index = r_ff.idx;
            m_rsp_in.reg_write_value = r_ff.val;
         end
         CMD_EXEC: begin
            if (r_ff.halt) begin
               m_rsp_in.status = ST_HALT;
            end else begin
               m_rsp_in.pc_after        = pc_next;
               m_rsp_in.executed_opcode = r_opc;
               case (r_opc)
                  OPC_ADD: begin
                     m_rsp_in.reg_write_valid = 1'b1;
                     m_rsp_in.reg_write_index = r_word_ff[15:12];
                     m_rsp_in.reg_write_value = sum_w[DATA_W-1:0];
                  end
                  OPC_LW: begin
                     // value filled in at write-back from the data store
                     m_rsp_in.reg_write_valid = 1'b1;
                     m_rsp_in.reg_write_index = r_word_ff[15:12];
                  end
                  OPC_SW: begin
                     m_rsp_in.mem_write_valid = 1'b1;
                     m_rsp_in.mem_write_addr  = rda_ff;
                     m_rsp_in.mem_write_value = rdb_ff;
                  end
                  OPC_BEQ, OPC_J: begin
                     m_rsp_in.status = ST_OK;
                  end
                  default: begin
                     m_rsp_in.status = ST_UNSUP;
                  end
               endcase
            end
         end
         default: begin
            m_rsp_in.status = ST_OK;
         end
      endcase

      r_lw = r_exec_ok && (r_opc == OPC_LW);
      r_sw = r_exec_ok && (r_opc == OPC_SW);

      // low byte sits in the bank picked by address bit 0, high byte in the other
      odd_idx  = rda_ff[DATA_W-1:1];
      even_idx = rda_ff[DATA_W-1:1] + BANK_AW'(rda_ff[0]);

      bank_we = clearing || r_sw;
      even_wa = clearing ? clr_ff : even_idx;
      odd_wa  = clearing ? clr_ff : odd_idx;
      if (clearing) begin
         even_wd = '0;
         odd_wd  = '0;
      end else if (rda_ff[0]) begin
         even_wd = rdb_ff[15:8];
         odd_wd  = rdb_ff[7:0];
      end else begin
         even_wd = rdb_ff[7:0];
         odd_wd  = rdb_ff[15:8];
      end

      m_vld_in = r_vld_ff;
      m_lw_in  = r_lw;
      m_a0_in  = rda_ff[0];
   end

   always_ff @(posedge clock) begin
      if (bank_we) begin
         ds_even[even_wa] <= even_wd;
         ds_odd[odd_wa]   <= odd_wd;
      end
      even_q_ff <= ds_even[even_idx];
      odd_q_ff  <= ds_odd[odd_idx];
   end

   // ---------------- write-back ----------------
   always_comb begin
      m_rsp = m_rsp_ff;
      if (m_lw_ff) begin
         m_rsp.reg_write_value = m_a0_ff ? {even_q_ff, odd_q_ff} : {odd_q_ff, even_q_ff};
      end
      rf_we   = m_vld_ff && m_rsp.reg_write_valid;
      rf_wi   = m_rsp.reg_write_index;
      rf_wd   = m_rsp.reg_write_value;
      fq_push = m_vld_ff;
   end

   // ---------------- response queue ----------------
   rsp_type                 fq_mem [FQ_DEPTH];

   always_comb begin
      rsp_valid = (fq_cnt_ff != '0);
      rsp_data  = fq_mem[fq_rp_ff];
      fq_pop    = rsp_valid && rsp_ready;
      fq_wp_in  = fq_push ? fq_wp_ff + FQ_AW'(1) : fq_wp_ff;
      fq_rp_in  = fq_pop ? fq_rp_ff + FQ_AW'(1) : fq_rp_ff;
      fq_cnt_in = fq_cnt_ff + (FQ_AW+1)'(fq_push) - (FQ_AW+1)'(fq_pop);
   end

   always_ff @(posedge clock) begin
      if (fq_push) fq_mem[fq_wp_ff] <= m_rsp;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff  <= 1'b0;
         r_vld_ff  <= 1'b0;
         m_vld_ff  <= 1'b0;
         pc_ff     <= '0;
         fq_cnt_ff <= '0;
         fq_wp_ff  <= '0;
         fq_rp_ff  <= '0;
      end else begin
         f_vld_ff  <= f_vld_in;
         r_vld_ff  <= r_vld_in;
         m_vld_ff  <= m_vld_in;
         pc_ff     <= pc_in;
         fq_cnt_ff <= fq_cnt_in;
         fq_wp_ff  <= fq_wp_in;
         fq_rp_ff  <= fq_rp_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff      <= f_in;
      r_ff      <= r_in;
      r_word_ff <= r_word_in;
      rda_ff    <= rda_in;
      rdb_ff    <= rdb_in;
      m_rsp_ff  <= m_rsp_in;
      m_lw_ff   <= m_lw_in;
      m_a0_ff   <= m_a0_in;
   end

   // ---------------- assertions ----------------
   a_fq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fq_push |-> (fq_cnt_ff != (FQ_AW+1)'(FQ_DEPTH)) || fq_pop)
      else $error("response queue overflow");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= (FQ_AW+2)'(FQ_DEPTH))
      else $error("more words in flight than queue slots");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !f_vld_ff && !r_vld_ff && !m_vld_ff && !rsp_valid)
      else $error("pipeline active during clearing pass");

   a_halt_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      (r_vld_ff && (r_ff.cmd == CMD_EXEC) && r_ff.halt) |=> (pc_ff == $past(pc_ff)))
      else $error("halted execute changed the PC");

endmodule

`default_nettype wire
